>>> rtl/swt_pkg.sv
package swt_pkg;

  localparam int WORD_BYTES_DEF = 1024;
  localparam int MAX_WORDS_DEF  = 64;

  // Results one line byte can cause: a trailing backslash byte, a word end and a line end.
  localparam int MAX_RESULTS = 3;
  localparam int RES_CNT_W   = 2;
  // Result queue depth, a power of two so that the pointers wrap by themselves.
  localparam int QUEUE_DEPTH = 4;
  localparam int IDX_W       = 6;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_LINE_END = 2'd2
  } kind_t;

  typedef struct packed {
    logic in_sq;
    logic in_dq;
    logic esc;
  } quote_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } result_t;

endpackage

>>> rtl/swt_decode.sv
module swt_decode
  import swt_pkg::*;
#(
  parameter int WORD_BYTES = WORD_BYTES_DEF,
  parameter int MAX_WORDS  = MAX_WORDS_DEF,
  localparam int LEN_W     = $clog2(WORD_BYTES),
  localparam int CNT_W     = $clog2(MAX_WORDS)
) (
  input  logic [7:0]                    ch,
  input  logic                          is_end,
  input  quote_t                        q,
  input  logic [LEN_W-1:0]              len,
  input  logic [CNT_W-1:0]              cnt,
  output quote_t                        q_nxt,
  output logic [LEN_W-1:0]              len_nxt,
  output logic [CNT_W-1:0]              cnt_nxt,
  output result_t [MAX_RESULTS-1:0]     res,
  output logic [RES_CNT_W-1:0]          n_res
);

  logic             do_add;
  logic             do_flush;
  logic [7:0]       add_b;
  logic             len_room;
  logic             cnt_room;
  logic             add_emit;
  logic             flush_hit;
  logic             flush_emit;
  logic [LEN_W-1:0] len1;
  logic [CNT_W-1:0] cnt1;
  quote_t           q_upd;
  logic [RES_CNT_W-1:0] n;

  // Classify the byte against the current quoting state.
  always_comb begin
    do_add   = 1'b0;
    do_flush = 1'b0;
    add_b    = ch;
    q_upd    = q;
    if (is_end) begin
      // A backslash still pending at line end is kept as a plain byte.
      do_add   = q.esc;
      add_b    = CH_BACKSLASH;
      do_flush = 1'b1;
    end else if (q.esc) begin
      q_upd.esc = 1'b0;
      do_add    = 1'b1;
    end else if (ch == CH_BACKSLASH) begin
      q_upd.esc = 1'b1;
    end else if (ch == CH_SQUOTE && !q.in_dq) begin
      q_upd.in_sq = !q.in_sq;
    end else if (ch == CH_DQUOTE && !q.in_sq) begin
      q_upd.in_dq = !q.in_dq;
    end else if (ch == CH_SPACE && !q.in_sq && !q.in_dq) begin
      do_flush = 1'b1;
    end else begin
      do_add = 1'b1;
    end
  end

  assign len_room   = len < LEN_W'(WORD_BYTES - 1);
  assign cnt_room   = cnt < CNT_W'(MAX_WORDS - 1);
  assign add_emit   = do_add && len_room && cnt_room;
  assign len1       = (do_add && len_room) ? len + LEN_W'(1) : len;
  assign flush_hit  = do_flush && (len1 != '0);
  assign flush_emit = flush_hit && cnt_room;
  assign cnt1       = flush_emit ? cnt + CNT_W'(1) : cnt;

  assign q_nxt   = is_end ? '0 : q_upd;
  assign len_nxt = (is_end || flush_hit) ? '0 : len1;
  assign cnt_nxt = is_end ? '0 : cnt1;

  // Pack the results in order; the final one carries last.
  always_comb begin
    res = '0;
    n   = '0;
    if (add_emit) begin
      res[n] = '{kind: KIND_BYTE, data: add_b, idx: IDX_W'(cnt), last: 1'b0};
      n      = n + RES_CNT_W'(1);
    end
    if (flush_emit) begin
      res[n] = '{kind: KIND_WORD_END, data: 8'h00, idx: IDX_W'(cnt), last: 1'b0};
      n      = n + RES_CNT_W'(1);
    end
    if (is_end) begin
      res[n] = '{kind: KIND_LINE_END, data: 8'h00, idx: IDX_W'(cnt1), last: 1'b0};
      n      = n + RES_CNT_W'(1);
    end
    if (n != '0) begin
      res[RES_CNT_W'(n - RES_CNT_W'(1))].last = 1'b1;
    end
  end

  assign n_res = n;

endmodule

>>> rtl/swt_queue.sv
module swt_queue
  import swt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  result_t [MAX_RESULTS-1:0] push_res,
  input  logic [RES_CNT_W-1:0]      push_n,
  input  logic                      out_stall,
  output logic                      room,
  output logic                      out_valid,
  output result_t                   head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

  result_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]      count_r, count_nxt;
  logic                pop;
  logic [RES_CNT_W-1:0] add_n;

  assign out_valid = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // A whole item's results must fit, counting the slot freed by this cycle's transfer.
  assign room      = (int'(count_r) + MAX_RESULTS) <= (QUEUE_DEPTH + int'(pop));
  assign add_n     = push ? push_n : '0;

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(add_n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + QCW'(add_n) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (push && (k < int'(push_n))) begin
        mem_r[PTR_W'(wr_ptr_r + PTR_W'(k))] <= push_res[k];
      end
    end
  end

endmodule

>>> rtl/shell_word_tokenizer.sv
// Channel | Ports                                                     | Direction
// input   | in_valid, in_stall, in_ch, in_is_end                      | in (stall out)
// result  | out_valid, out_stall, out_kind, out_out_byte,             | out (stall in)
//         | out_word_index, out_last                                  |
//
// A byte is held in the input register and decoded from there; its results land in a
// four-entry queue and reach the output from its head. One byte is taken per cycle
// while each byte yields at most one result and out_stall is low; the output port
// then sets the rate, at one result per cycle (a line end may cause three).
// Reset clears the quoting state, both counters and the queue.
// A stall on the output holds the queue head; the input stalls while a byte waits in
// the input register and the queue has fewer than three free slots, counting the slot
// freed by this cycle's output transfer.
module shell_word_tokenizer
  import swt_pkg::*;
#(
  parameter int WORD_BYTES = WORD_BYTES_DEF,
  parameter int MAX_WORDS  = MAX_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_ch,
  input  logic             in_is_end,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_out_byte,
  output logic [IDX_W-1:0] out_word_index,
  output logic             out_last
);

  localparam int LEN_W = $clog2(WORD_BYTES);
  localparam int CNT_W = $clog2(MAX_WORDS);

  logic                      in_valid_r, in_valid_nxt;
  logic [7:0]                in_ch_r;
  logic                      in_end_r;
  quote_t                    quote_r, quote_nxt;
  logic [LEN_W-1:0]          word_len_r, word_len_nxt;
  logic [CNT_W-1:0]          word_cnt_r, word_cnt_nxt;
  result_t [MAX_RESULTS-1:0] res;
  logic [RES_CNT_W-1:0]      n_res;
  logic                      room;
  logic                      adv;
  logic                      in_xfer;
  result_t                   head;

  assign adv      = in_valid_r && room;
  assign in_stall = in_valid_r && !room;
  assign in_xfer  = in_valid && !in_stall;

  assign in_valid_nxt = in_xfer || (in_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      quote_r    <= '0;
      word_len_r <= '0;
      word_cnt_r <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (adv) begin
        quote_r    <= quote_nxt;
        word_len_r <= word_len_nxt;
        word_cnt_r <= word_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_ch_r  <= in_ch;
      in_end_r <= in_is_end;
    end
  end

  swt_decode #(
    .WORD_BYTES (WORD_BYTES),
    .MAX_WORDS  (MAX_WORDS)
  ) u_decode (
    .ch      (in_ch_r),
    .is_end  (in_end_r),
    .q       (quote_r),
    .len     (word_len_r),
    .cnt     (word_cnt_r),
    .q_nxt   (quote_nxt),
    .len_nxt (word_len_nxt),
    .cnt_nxt (word_cnt_nxt),
    .res     (res),
    .n_res   (n_res)
  );

  swt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .push_res  (res),
    .push_n    (n_res),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_kind       = head.kind;
  assign out_out_byte   = head.data;
  assign out_word_index = head.idx;
  assign out_last       = head.last;

  // A line end is always the final result of its byte.
  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_LINE_END) |-> out_last)
    else $error("line end result without last");

  // Closing a line returns all per-line state to its reset values.
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_end_r) |=> (quote_r == '0 && word_len_r == '0 && word_cnt_r == '0))
    else $error("line state not cleared after line end");

  // Only word bytes carry data.
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_BYTE) |-> (out_out_byte == 8'h00))
    else $error("nonzero byte on a marker result");

  // A decoded line end always produces at least its line end result.
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_end_r) |-> (n_res != '0))
    else $error("line end produced no result");

endmodule
